// File: hdl/lts_pkg.sv
// -----------------------------------------------------------------------------
// Lottery task scheduler package
// Shared operation and status codes, the probe that travels the slot chain,
// the commit record and the mixing constants of the random draw.
// -----------------------------------------------------------------------------
package lts_pkg;

	localparam int TID_W  = 16;
	localparam int TKT_W  = 16;
	localparam int CORE_W = 3;
	// Widths sized for the largest table the parameters allow.
	localparam int BKT_W  = 9;
	localparam int IDX_W  = 14;
	localparam int SUM_W  = 30;

	localparam logic [63:0] MIX_A  = 64'h385B4D8F624F9B19;
	localparam logic [63:0] MIX_B  = 64'hED32CA69BFBBDD6F;
	localparam logic [63:0] MIX_C  = 64'hDC6BCBFB0FDF4EFB;
	localparam logic [63:0] MIX_D  = 64'h398A24ED505550E7;
	localparam logic [63:0] MIX_DA = 64'(MIX_D * MIX_A);

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_LOOK  = 2'd1,
		OP_FLAGS = 2'd2,
		OP_SCHED = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DUP  = 2'd1,
		ST_FULL = 2'd2,
		ST_MISS = 2'd3
	} status_t;

	typedef struct packed {
		logic              active;
		op_t               op;
		logic [TID_W-1:0]  tid;
		logic [TKT_W-1:0]  tickets;
		logic [CORE_W-1:0] core;
		logic              paused;
		logic              dead;
		logic              invl;
		logic [BKT_W-1:0]  bucket;
		logic              dup;
		logic              placed;
		logic              hit;
		logic              won;
		logic [IDX_W-1:0]  idx;
		logic [TID_W-1:0]  win_tid;
		logic [SUM_W-1:0]  sum;
		logic [SUM_W-1:0]  golden;
	} probe_t;

	typedef struct packed {
		logic             en;
		logic             won;
		logic [IDX_W-1:0] idx;
	} commit_t;

endpackage

// File: hdl/lts_if.sv
// -----------------------------------------------------------------------------
// Lottery task scheduler channels
// Valid/ready interfaces for the request and the result channel.
// -----------------------------------------------------------------------------
interface lts_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] tid;
	logic [15:0] tickets;
	logic [2:0]  core;
	logic        paused;
	logic        dead;
	logic        invalidated;
	logic [63:0] timer_time;

	modport source (output valid, kind, tid, tickets, core, paused, dead, invalidated,
		timer_time, input ready);
	modport sink (input valid, kind, tid, tickets, core, paused, dead, invalidated,
		timer_time, output ready);
endinterface

interface lts_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        found;
	logic [15:0] chosen_tid;
	logic        went_idle;

	modport source (output valid, status, found, chosen_tid, went_idle, input ready);
	modport sink (input valid, status, found, chosen_tid, went_idle, output ready);
endinterface

// File: hdl/lts_cell.sv
// -----------------------------------------------------------------------------
// Lottery task scheduler slot cell
// Holds one task slot and updates the probe that passes through it.
// -----------------------------------------------------------------------------
module lts_cell import lts_pkg::*; #(
	parameter int K   = 0,
	parameter int BKT = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  probe_t            p_in,
	input  commit_t           cm,
	input  logic [CORE_W-1:0] core_num,
	output probe_t            p_out
);

	logic              used_q;
	logic [TID_W-1:0]  tid_q;
	logic [TKT_W-1:0]  tkt_q;
	logic [CORE_W-1:0] core_q;
	logic              paused_q;
	logic              dead_q;
	logic              invl_q;
	logic              run_q;
	probe_t            p_q;

	probe_t            n;
	logic              bkt_hit;
	logic              elig;
	logic              wr_add;
	logic              wr_flags;
	logic [SUM_W-1:0]  sum_nx;

	always_comb begin
		n        = p_in;
		wr_add   = 1'b0;
		wr_flags = 1'b0;
		bkt_hit  = (p_in.bucket == BKT_W'(BKT));
		sum_nx   = p_in.sum + SUM_W'(tkt_q);
		elig     = used_q && !((dead_q && !invl_q) || paused_q || run_q) && (core_q == core_num);
		if (p_in.active) begin
			case (p_in.op)
				OP_ADD: begin
					if (bkt_hit && used_q && tid_q == p_in.tid) begin
						n.dup = 1'b1;
					end
					// Slots fill in order, so the first free one of the bucket comes
					// after every occupied one that could hold a duplicate.
					if (bkt_hit && !used_q && !p_in.dup && !p_in.placed) begin
						wr_add   = 1'b1;
						n.placed = 1'b1;
					end
				end
				OP_LOOK, OP_FLAGS: begin
					if (bkt_hit && used_q && tid_q == p_in.tid) begin
						n.hit    = 1'b1;
						wr_flags = (p_in.op == OP_FLAGS);
					end
				end
				OP_SCHED: begin
					if (!p_in.won && elig) begin
						n.sum = sum_nx;
						if (sum_nx >= p_in.golden) begin
							n.won     = 1'b1;
							n.idx     = IDX_W'(K);
							n.win_tid = tid_q;
						end
					end
				end
				default: begin
					n = p_in;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			p_q    <= '0;
		end else begin
			p_q <= n;
			if (wr_add) begin
				used_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_add) begin
			tid_q    <= p_in.tid;
			tkt_q    <= p_in.tickets;
			core_q   <= p_in.core;
			paused_q <= 1'b0;
			dead_q   <= 1'b0;
			invl_q   <= 1'b0;
			run_q    <= 1'b0;
		end else if (wr_flags) begin
			paused_q <= p_in.paused;
			dead_q   <= p_in.dead;
			invl_q   <= p_in.invl;
		end else if (cm.en) begin
			// Only the current task can be running, so the switch rewrites every mark.
			run_q <= cm.won && (cm.idx == IDX_W'(K));
		end
	end

	assign p_out = p_q;

endmodule

// File: hdl/lts_div.sv
// -----------------------------------------------------------------------------
// Lottery task scheduler remainder unit
// Restoring division, one dividend bit per cycle, returning the remainder.
// -----------------------------------------------------------------------------
module lts_div import lts_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [63:0]      num,
	input  logic [SUM_W-1:0] den,
	output logic             done,
	output logic [SUM_W-1:0] rem
);

	logic             busy_q;
	logic             done_q;
	logic [5:0]       cnt_q;
	logic [63:0]      num_q;
	logic [SUM_W-1:0] den_q;
	logic [SUM_W-1:0] rem_q;
	logic [SUM_W:0]   trial;

	assign trial = {rem_q, num_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[62:0], 1'b0};
			// The remainder stays below the divisor, so the trial fits in one more bit.
			if (trial >= {1'b0, den_q}) begin
				rem_q <= SUM_W'(trial - {1'b0, den_q});
			end else begin
				rem_q <= SUM_W'(trial);
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// File: hdl/lts_mix.sv
// -----------------------------------------------------------------------------
// Lottery task scheduler random mixer
// Scrambles the seed with two 64-bit constant products, each built from
// three 32x32 partial products on one shared multiplier.
// -----------------------------------------------------------------------------
module lts_mix import lts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] seed,
	output logic        done,
	output logic [63:0] result
);

	typedef enum logic [1:0] {
		M_IDLE,
		M_PRE,
		M_MUL
	} mstate_t;

	mstate_t     state_q;
	logic [1:0]  ph_q;
	logic        pass_q;
	logic        done_q;
	logic [63:0] seed_q;
	logic [63:0] x_q;
	logic [63:0] mul_q;
	logic [63:0] acc_q;
	logic [31:0] hi_q;
	logic [63:0] res_q;

	logic [63:0] k;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] pre;
	logic [63:0] prod;
	logic [63:0] post0;
	logic [63:0] post1;
	logic [63:0] t0;
	logic [63:0] t1;

	always_comb begin
		k     = pass_q ? MIX_C : MIX_A;
		mul_a = (ph_q == 2'd2) ? x_q[63:32] : x_q[31:0];
		mul_b = (ph_q == 2'd1) ? k[63:32] : k[31:0];
		t0    = seed_q + MIX_DA;
		pre   = t0 ^ (t0 >> 23);
		prod  = acc_q + {mul_q[31:0] + hi_q, 32'd0};
		t1    = prod ^ (prod >> 47);
		post0 = t1 ^ (MIX_B >> t1[4:0]);
		post1 = (prod ^ (prod >> 13)) ^ MIX_D;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			ph_q    <= '0;
			pass_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (start) begin
						state_q <= M_PRE;
					end
				end
				M_PRE: begin
					state_q <= M_MUL;
					ph_q    <= 2'd0;
					pass_q  <= 1'b0;
				end
				M_MUL: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd3) begin
						if (pass_q) begin
							state_q <= M_IDLE;
							done_q  <= 1'b1;
						end else begin
							pass_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			seed_q <= seed;
		end
		mul_q <= mul_a * mul_b;
		if (state_q == M_PRE) begin
			x_q <= pre;
		end
		if (state_q == M_MUL) begin
			case (ph_q)
				2'd1: acc_q <= mul_q;
				2'd2: hi_q  <= mul_q[31:0];
				2'd3: begin
					if (pass_q) begin
						res_q <= post1;
					end else begin
						x_q <= post0;
					end
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// File: hdl/lottery_task_scheduler.sv
// -----------------------------------------------------------------------------
// Lottery task scheduler
// Hashed task table held in a chain of slot cells, with a lottery pick.
// -----------------------------------------------------------------------------
// Add, lookup and set flags: the bucket index is taken first, then the probe walks the cell chain.
// Schedule: the mixer, then the remainder of the draw, then the chain walk; with an empty table
// there is no draw and no walk, and the result goes straight to the finish.
// One request is in flight at a time; a held result delays only the finish of the next.
// Asynchronous reset empties the table and returns the registers to their defaults.
module lottery_task_scheduler import lts_pkg::*; #(
	parameter int BUCKETS          = 16,
	parameter int SLOTS_PER_BUCKET = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	lts_req_if.sink     in_ch,
	lts_rsp_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int NSLOTS   = BUCKETS * SLOTS_PER_BUCKET;
	localparam int CNT_W    = $clog2(NSLOTS + 1);
	// The bucket index is tid mod BUCKETS, taken by a reciprocal multiplication
	// that is exact for every 16-bit tid.
	localparam int BKT_L    = $clog2(BUCKETS);
	localparam int RECIP_SH = TID_W + BKT_L;
	localparam int RECIP_W  = TID_W + 1;
	localparam int PROD_W   = TID_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(((longint'(1) << RECIP_SH)
		+ longint'(BUCKETS) - longint'(1)) / longint'(BUCKETS));

	typedef enum logic [2:0] {
		S_IDLE,
		S_BKT,
		S_MIX,
		S_MOD,
		S_WALK,
		S_FIN
	} state_t;

	state_t            state_q;
	probe_t            req_q;
	probe_t            launch_q;
	commit_t           commit_q;
	probe_t            chain [NSLOTS+1];
	logic [CORE_W-1:0] core_num_q;
	logic              has_timer_q;
	logic [63:0]       seed_cnt_q;
	logic [CNT_W-1:0]  task_total_q;
	logic [SUM_W-1:0]  ticket_total_q;
	logic [TID_W-1:0]  bkt_quo_q;

	logic              div_start_q;
	logic [63:0]       div_num_q;
	logic [SUM_W-1:0]  div_den_q;
	logic              div_done;
	logic [SUM_W-1:0]  div_rem;
	logic              mix_start_q;
	logic [63:0]       mix_seed_q;
	logic              mix_done;
	logic [63:0]       mix_res;

	status_t           res_status_q;
	logic              res_found_q;
	logic [TID_W-1:0]  res_tid_q;
	logic              res_idle_q;
	logic              out_valid_q;
	status_t           out_status_q;
	logic              out_found_q;
	logic [TID_W-1:0]  out_tid_q;
	logic              out_idle_q;

	probe_t            pe;
	logic              in_fire;
	logic              cfg_wr;
	logic [PROD_W-1:0] bkt_prod;
	probe_t            launch_nx;
	logic              launch_go;
	commit_t           commit_nx;
	logic              sched_go;
	logic              fin_go;

	assign pe      = chain[NSLOTS];
	assign in_fire = in_ch.valid && in_ch.ready;
	assign cfg_wr  = psel && penable && pwrite;

	assign in_ch.ready = (state_q == S_IDLE);
	assign pready      = 1'b1;
	assign prdata      = paddr[2] ? {31'd0, has_timer_q} : {29'd0, core_num_q};

	assign bkt_prod  = PROD_W'(in_ch.tid) * PROD_W'(RECIP_M);
	assign launch_go = (state_q == S_BKT) || (state_q == S_MOD && div_done);
	assign sched_go  = in_fire && (op_t'(in_ch.kind) == OP_SCHED) && (task_total_q != '0);
	assign fin_go    = (state_q == S_FIN) && (!out_valid_q || out_ch.ready);

	always_comb begin
		launch_nx        = req_q;
		launch_nx.active = 1'b1;
		if (state_q == S_BKT) begin
			launch_nx.bucket = BKT_W'(req_q.tid - TID_W'(bkt_quo_q * TID_W'(BUCKETS)));
		end else begin
			launch_nx.golden = div_rem;
		end
	end

	always_comb begin
		commit_nx = '0;
		if (state_q == S_IDLE && in_fire && op_t'(in_ch.kind) == OP_SCHED
				&& task_total_q == '0) begin
			// Empty table: no draw, the idle task runs.
			commit_nx = '{en: 1'b1, won: 1'b0, idx: '0};
		end else if (state_q == S_WALK && pe.active && pe.op == OP_SCHED) begin
			commit_nx = '{en: 1'b1, won: pe.won, idx: pe.idx};
		end
	end

	assign chain[0] = launch_q;

	for (genvar g = 0; g < NSLOTS; g++) begin : g_cell
		lts_cell #(
			.K   (g),
			.BKT (g / SLOTS_PER_BUCKET)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.p_in     (chain[g]),
			.cm       (commit_q),
			.core_num (core_num_q),
			.p_out    (chain[g+1])
		);
	end

	lts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (div_num_q),
		.den    (div_den_q),
		.done   (div_done),
		.rem    (div_rem)
	);

	lts_mix u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mix_start_q),
		.seed   (mix_seed_q),
		.done   (mix_done),
		.result (mix_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			launch_q       <= '0;
			commit_q       <= '0;
			core_num_q     <= '0;
			has_timer_q    <= 1'b1;
			seed_cnt_q     <= MIX_D;
			task_total_q   <= '0;
			ticket_total_q <= '0;
			div_start_q    <= 1'b0;
			mix_start_q    <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			launch_q    <= launch_go ? launch_nx : '0;
			commit_q    <= commit_nx;
			div_start_q <= (state_q == S_MIX) && mix_done;
			mix_start_q <= sched_go;
			if (cfg_wr) begin
				if (paddr[2]) begin
					has_timer_q <= pwdata[0];
				end else begin
					core_num_q <= pwdata[CORE_W-1:0];
				end
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (op_t'(in_ch.kind) != OP_SCHED) begin
							state_q <= S_BKT;
						end else if (task_total_q == '0) begin
							state_q <= S_FIN;
						end else begin
							if (!has_timer_q) begin
								seed_cnt_q <= seed_cnt_q + 64'd1;
							end
							state_q <= S_MIX;
						end
					end
				end
				S_BKT: begin
					state_q <= S_WALK;
				end
				S_MIX: begin
					if (mix_done) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (div_done) begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (pe.active) begin
						if (pe.op == OP_ADD && !pe.dup && pe.placed) begin
							task_total_q   <= task_total_q + CNT_W'(1);
							ticket_total_q <= ticket_total_q + SUM_W'(pe.tickets);
						end
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q <= '{
				op:      op_t'(in_ch.kind),
				tid:     in_ch.tid,
				tickets: in_ch.tickets,
				core:    in_ch.core,
				paused:  in_ch.paused,
				dead:    in_ch.dead,
				invl:    in_ch.invalidated,
				default: '0
			};
			bkt_quo_q     <= TID_W'(bkt_prod >> RECIP_SH);
			mix_seed_q    <= has_timer_q ? in_ch.timer_time : seed_cnt_q;
			res_status_q  <= ST_OK;
			res_found_q   <= 1'b0;
			res_tid_q     <= '0;
			res_idle_q    <= (op_t'(in_ch.kind) == OP_SCHED);
		end
		if (state_q == S_MIX && mix_done) begin
			div_num_q <= mix_res;
			div_den_q <= (ticket_total_q == '0) ? SUM_W'(1) : ticket_total_q;
		end
		if (state_q == S_WALK && pe.active) begin
			case (pe.op)
				OP_ADD: begin
					res_status_q <= pe.dup ? ST_DUP : (pe.placed ? ST_OK : ST_FULL);
				end
				OP_LOOK, OP_FLAGS: begin
					res_status_q <= pe.hit ? ST_OK : ST_MISS;
					res_found_q  <= pe.hit;
					res_tid_q    <= pe.hit ? pe.tid : '0;
				end
				OP_SCHED: begin
					res_found_q <= pe.won;
					res_tid_q   <= pe.won ? pe.win_tid : '0;
					res_idle_q  <= !pe.won;
				end
				default: begin
					res_status_q <= ST_OK;
				end
			endcase
		end
		if (fin_go) begin
			out_status_q <= res_status_q;
			out_found_q  <= res_found_q;
			out_tid_q    <= res_tid_q;
			out_idle_q   <= res_idle_q;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.status     = out_status_q;
	assign out_ch.found      = out_found_q;
	assign out_ch.chosen_tid = out_tid_q;
	assign out_ch.went_idle  = out_idle_q;

endmodule

// File: bench/testbench.sv
// -----------------------------------------------------------------------------
// Lottery task scheduler testbench
// Drives add, lookup, set-flags and schedule requests with random gaps and
// result stalls. A bit-true predictor of the task table and the lottery draw
// checks every result. Both registers are changed between phases.
// -----------------------------------------------------------------------------
import lts_pkg::*;

class task_table_scoreboard;
	typedef struct {
		status_t     status;
		logic        found;
		logic [15:0] tid;
		logic        idle;
	} outcome_t;

	localparam int NB = 16;
	localparam int NS = 4;
	localparam logic [3:0] MK_PAUSED = 4'd1;
	localparam logic [3:0] MK_DEAD   = 4'd2;
	localparam logic [3:0] MK_INVL   = 4'd4;
	localparam logic [3:0] MK_RUN    = 4'd8;

	logic [15:0] tids [NB*NS];
	logic [15:0] tkts [NB*NS];
	logic [2:0]  cores [NB*NS];
	logic [3:0]  marks [NB*NS];
	int unsigned fill [NB];
	int unsigned tasks_held;
	logic [63:0] ticket_sum;
	logic [63:0] seed_count;
	bit          running_valid;
	int unsigned running_slot;
	logic [2:0]  core_number;
	logic        has_timer;
	outcome_t    pending_q [$];
	int unsigned errors;

	function new();
		for (int b = 0; b < NB; b++)
			fill[b] = 0;
		tasks_held = 0;
		ticket_sum = 0;
		seed_count = MIX_D;
		running_valid = 0;
		running_slot = 0;
		core_number = 0;
		has_timer = 1;
		errors = 0;
	endfunction

	function logic [63:0] mix_draw(logic [63:0] timer);
		logic [63:0] n;
		if (has_timer) begin
			n = timer;
		end else begin
			n = seed_count;
			seed_count = seed_count + 64'd1;
		end
		n = n + MIX_DA;
		n = n ^ (n >> 23);
		n = n * MIX_A;
		n = n ^ (n >> 47);
		n = n ^ (MIX_B >> n[4:0]);
		n = n * MIX_C;
		n = n ^ (n >> 13);
		n = n ^ MIX_D;
		return n;
	endfunction

	function int slot_of(logic [15:0] tid);
		int b;
		b = tid % NB;
		for (int j = 0; j < fill[b]; j++)
			if (tids[b*NS+j] == tid)
				return b*NS + j;
		return -1;
	endfunction

	function int unsigned pending();
		return pending_q.size();
	endfunction

	function void note_request(op_t kind, logic [15:0] tid, logic [15:0] tk, logic [2:0] core,
			logic paused, logic dead, logic invl, logic [63:0] timer);
		outcome_t o;
		int s, b, win;
		bit won;
		logic [63:0] golden, run_sum;
		o.status = ST_OK;
		o.found = 0;
		o.tid = 0;
		o.idle = 0;
		case (kind)
			OP_ADD: begin
				b = tid % NB;
				if (slot_of(tid) >= 0) begin
					o.status = ST_DUP;
				end else if (fill[b] >= NS) begin
					o.status = ST_FULL;
				end else begin
					s = b*NS + fill[b];
					tids[s] = tid;
					tkts[s] = tk;
					cores[s] = core;
					marks[s] = 0;
					fill[b]++;
					tasks_held++;
					ticket_sum += tk;
				end
			end
			OP_LOOK, OP_FLAGS: begin
				s = slot_of(tid);
				if (s < 0) begin
					o.status = ST_MISS;
				end else begin
					o.found = 1;
					o.tid = tid;
					if (kind == OP_FLAGS)
						marks[s] = (marks[s] & MK_RUN) | (paused ? MK_PAUSED : 4'd0)
							| (dead ? MK_DEAD : 4'd0) | (invl ? MK_INVL : 4'd0);
				end
			end
			default: begin
				won = 0;
				win = 0;
				if (tasks_held > 0) begin
					golden = mix_draw(timer) % (ticket_sum == 0 ? 64'd1 : ticket_sum);
					run_sum = 0;
					for (int i = 0; i < NB && !won; i++) begin
						for (int j = 0; j < fill[i] && !won; j++) begin
							s = i*NS + j;
							// A dead task stays eligible only once it has been invalidated.
							if (((marks[s] & MK_DEAD) != 0 && (marks[s] & MK_INVL) == 0)
									|| (marks[s] & (MK_PAUSED | MK_RUN)) != 0)
								continue;
							if (cores[s] != core_number)
								continue;
							run_sum += tkts[s];
							if (run_sum >= golden) begin
								won = 1;
								win = s;
							end
						end
					end
				end
				if (running_valid)
					marks[running_slot] = marks[running_slot] & ~MK_RUN;
				if (won) begin
					marks[win] = marks[win] | MK_RUN;
					running_valid = 1;
					running_slot = win;
					o.found = 1;
					o.tid = tids[win];
				end else begin
					running_valid = 0;
					running_slot = 0;
					o.idle = 1;
				end
			end
		endcase
		pending_q.push_back(o);
	endfunction

	function void check_result(logic [1:0] status, logic found, logic [15:0] tid, logic idle);
		outcome_t o;
		if (pending_q.size() == 0) begin
			$display("%0t: unexpected result status=%0d found=%0d tid=%0d idle=%0d",
				$time, status, found, tid, idle);
			errors++;
			return;
		end
		o = pending_q.pop_front();
		if (status !== o.status) begin
			$display("%0t: status expected %0d, got %0d", $time, o.status, status);
			errors++;
		end
		if (found !== o.found) begin
			$display("%0t: found expected %0d, got %0d", $time, o.found, found);
			errors++;
		end
		if (tid !== o.tid) begin
			$display("%0t: chosen_tid expected %0d, got %0d", $time, o.tid, tid);
			errors++;
		end
		if (idle !== o.idle) begin
			$display("%0t: went_idle expected %0d, got %0d", $time, o.idle, idle);
			errors++;
		end
	endfunction
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] ADDR_CORE  = 3'd0;
	localparam logic [2:0] ADDR_TIMER = 3'd4;
	localparam int DRAIN_CYCLES = 200;
	localparam longint CYCLE_LIMIT = 3000000;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	longint      cycles;
	bit          quiet;

	lts_req_if req ();
	lts_rsp_if rsp ();

	task_table_scoreboard sb;

	lottery_task_scheduler dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (req),
		.out_ch  (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 4);
		return $urandom_range(5, 120);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Result side: check on transfer, then choose the next ready level.
	int stall_left;
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_result(rsp.status, rsp.found, rsp.chosen_tid, rsp.went_idle);
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp.ready <= 1'b0;
		end else begin
			stall_left <= pick_gap();
			rsp.ready <= 1'b1;
		end
	end

	task automatic send(op_t kind, logic [15:0] tid, logic [15:0] tk, logic [2:0] core,
			logic paused, logic dead, logic invl, logic [63:0] timer);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.kind <= kind;
		req.tid <= tid;
		req.tickets <= tk;
		req.core <= core;
		req.paused <= paused;
		req.dead <= dead;
		req.invalidated <= invl;
		req.timer_time <= timer;
		do @(posedge clk); while (!req.ready);
		sb.note_request(kind, tid, tk, core, paused, dead, invl, timer);
	endtask

	task automatic wait_idle();
		req.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_CORE)
			sb.core_number = data[2:0];
		else
			sb.has_timer = data[0];
	endtask

	task automatic random_request();
		int r;
		op_t kind;
		logic [15:0] tid;
		logic [2:0] core;
		r = $urandom_range(0, 99);
		kind = r < 30 ? OP_ADD : r < 48 ? OP_LOOK : r < 65 ? OP_FLAGS : OP_SCHED;
		tid = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 95)) : 16'($urandom);
		core = ($urandom_range(0, 1) == 1) ? sb.core_number : 3'($urandom);
		send(kind, tid, 16'($urandom), core, $urandom_range(0, 99) < 20,
			$urandom_range(0, 99) < 30, $urandom_range(0, 1), {$urandom, $urandom});
	endtask

	initial begin
		sb = new();
		quiet = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req.valid = 1'b0;
		req.kind = OP_ADD;
		req.tid = '0;
		req.tickets = '0;
		req.core = '0;
		req.paused = 1'b0;
		req.dead = 1'b0;
		req.invalidated = 1'b0;
		req.timer_time = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, misses, zero ticket total, full bucket, flag rules.
		send(OP_SCHED, 16'd0, 16'd0, 3'd0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
		send(OP_LOOK, 16'd0, 16'd0, 3'd0, 0, 0, 0, 64'd0);
		send(OP_FLAGS, 16'hFFFF, 16'd0, 3'd0, 1, 1, 1, 64'd0);
		send(OP_ADD, 16'd0, 16'd0, 3'd0, 0, 0, 0, 64'd0);
		send(OP_SCHED, 16'd0, 16'd0, 3'd0, 0, 0, 0, 64'd0);
		send(OP_ADD, 16'd16, 16'hFFFF, 3'd0, 0, 0, 0, 64'd0);
		send(OP_ADD, 16'd32, 16'd1, 3'd0, 0, 0, 0, 64'd0);
		send(OP_ADD, 16'd48, 16'd500, 3'd0, 0, 0, 0, 64'd0);
		send(OP_ADD, 16'd64, 16'd7, 3'd0, 0, 0, 0, 64'd0);
		send(OP_ADD, 16'd16, 16'd3, 3'd0, 0, 0, 0, 64'd0);
		send(OP_LOOK, 16'd16, 16'd0, 3'd0, 0, 0, 0, 64'd0);
		send(OP_FLAGS, 16'd0, 16'd0, 3'd0, 1, 0, 0, 64'd0);
		send(OP_FLAGS, 16'd32, 16'd0, 3'd0, 0, 1, 0, 64'd0);
		send(OP_SCHED, 16'd0, 16'd0, 3'd0, 0, 0, 0, 64'h0123_4567_89AB_CDEF);
		send(OP_FLAGS, 16'd32, 16'd0, 3'd0, 0, 1, 1, 64'd0);
		send(OP_SCHED, 16'd0, 16'd0, 3'd0, 0, 0, 0, 64'h8000_0000_0000_0000);
		send(OP_ADD, 16'hFFFF, 16'hFFFF, 3'd7, 0, 0, 0, 64'd0);
		send(OP_FLAGS, 16'hFFFF, 16'd0, 3'd0, 0, 0, 0, 64'd0);
		send(OP_SCHED, 16'd0, 16'd0, 3'd0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
		wait_idle();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					reg_write(ADDR_CORE, 32'd0);
					reg_write(ADDR_TIMER, 32'd0);
				end
				1: reg_write(ADDR_CORE, 32'd7);
				2: reg_write(ADDR_TIMER, 32'd1);
				default: begin
					reg_write(ADDR_CORE, $urandom);
					reg_write(ADDR_TIMER, $urandom);
				end
			endcase
			for (int n = 0; n < 172; n++) begin
				if (n % 40 == 0)
					quiet = $urandom_range(0, 3) == 0;
				random_request();
			end
			wait_idle();
		end

		if (sb.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
